@@ rtl/core/otsu_pkg.sv @@
// Shared types for the Otsu threshold search block.
`default_nettype none
package otsu_pkg;
    typedef enum logic [3:0] {
        S_INIT,
        S_ACC,
        S_DRAIN,
        S_SCAN_RD,
        S_SCAN_WAIT,
        S_MUL_PA,
        S_MUL_PB,
        S_MUL_SQ,
        S_MUL_DEN,
        S_MUL_L,
        S_MUL_R,
        S_OUT
    } t_state;

    localparam int LEVELS = 256;
endpackage
`default_nettype wire

@@ rtl/core/otsu_threshold_search.sv @@
// Otsu threshold search: histogram memory, level scan and serial multiplier.
`default_nettype none
// Pixels are counted into a 256-entry histogram memory at one request per clock; a
// read-modify-write pipeline with one-deep forwarding handles repeated grey levels.
// After the request flagged last, the block passes through a drain state and then
// scans the 256 bins in order, clearing each as it is read. Each level that is
// compared takes the bin read in S_SCAN_RD and S_SCAN_WAIT plus up to six products
// on one shift-add multiplier, each product adding and shifting until its multiplier
// operand is zero. The result is held until taken; input requests are refused from
// the last pixel until then. After reset a clearing pass over all 256 bins zeroes
// the histogram before the first pixel is taken.
module otsu_threshold_search #(
    parameter int COUNT_BITS = 20
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_pixel,
    input  wire logic       i_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_threshold
);
    import otsu_pkg::*;

    localparam int CB = COUNT_BITS;
    localparam int SW = CB + 16;
    localparam int PW = SW + CB;
    localparam int LW = 2 * PW + 2 * CB;

    logic [CB-1:0] r_mem [LEVELS];
    logic [CB-1:0] r_rd;
    logic          mem_we;
    logic [7:0]    mem_wa;
    logic [CB-1:0] mem_wd;
    logic          mem_re;
    logic [7:0]    mem_ra;

    t_state r_state, n_state;

    logic          r_p1_valid;
    logic [7:0]    r_p1_addr;
    logic          r_fw_valid;
    logic [7:0]    r_fw_addr;
    logic [CB-1:0] r_fw_data;
    logic [CB-1:0] cur_cnt;
    logic [CB-1:0] new_cnt;
    logic [CB-1:0] cap;

    logic [CB-1:0] r_total, n_total;
    logic [SW-1:0] r_sum, n_sum;
    logic [7:0]    r_lvl, n_lvl;
    logic [CB-1:0] r_wb, n_wb;
    logic [CB-1:0] r_wf, n_wf;
    logic [SW-1:0] r_sumb, n_sumb;
    logic [SW-1:0] r_sumf, n_sumf;
    logic          r_stop, n_stop;
    logic [PW-1:0] r_pa, n_pa;
    logic [2*PW-1:0] r_sq, n_sq;
    logic [2*CB-1:0] r_den, n_den;
    logic [LW-1:0] r_l, n_l;
    logic          r_have, n_have;
    logic [2*PW-1:0] r_best_sq, n_best_sq;
    logic [2*CB-1:0] r_best_den, n_best_den;
    logic [7:0]    r_best_lvl, n_best_lvl;
    logic [7:0]    r_thr, n_thr;

    logic [LW-1:0] r_ma, n_ma;
    logic [PW-1:0] r_mb, n_mb;
    logic [LW-1:0] r_acc, n_acc;
    logic          mul_done;

    logic [CB:0]   wb_next;
    logic [CB+7:0] lvl_prod;
    logic [SW-1:0] sumb_next;
    logic [PW-1:0] pb_val;
    logic [PW-1:0] num_val;

    assign cap      = {CB{1'b1}};
    assign cur_cnt  = (r_fw_valid && r_fw_addr == r_p1_addr) ? r_fw_data : r_rd;
    assign new_cnt  = (cur_cnt == cap) ? cur_cnt : cur_cnt + 1'b1;
    assign mul_done = (r_mb == '0);
    assign wb_next  = {1'b0, r_wb} + {1'b0, r_rd};
    assign lvl_prod = (CB+8)'(r_lvl) * (CB+8)'(r_rd);
    assign sumb_next = r_sumb + SW'(lvl_prod);
    assign pb_val   = r_acc[PW-1:0];
    assign num_val  = (r_pa >= pb_val) ? r_pa - pb_val : pb_val - r_pa;

    assign o_ready     = (r_state == S_ACC);
    assign o_valid     = (r_state == S_OUT);
    assign o_threshold = r_thr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_p1_valid <= 1'b0;
            r_fw_valid <= 1'b0;
            r_total    <= '0;
            r_sum      <= '0;
            r_lvl      <= '0;
            r_stop     <= 1'b0;
            r_have     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_p1_valid <= i_valid && o_ready;
            r_fw_valid <= r_p1_valid;
            r_total    <= n_total;
            r_sum      <= n_sum;
            r_lvl      <= n_lvl;
            r_stop     <= n_stop;
            r_have     <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_addr  <= i_pixel;
        r_fw_addr  <= r_p1_addr;
        r_fw_data  <= new_cnt;
        r_wb       <= n_wb;
        r_wf       <= n_wf;
        r_sumb     <= n_sumb;
        r_sumf     <= n_sumf;
        r_pa       <= n_pa;
        r_sq       <= n_sq;
        r_den      <= n_den;
        r_l        <= n_l;
        r_best_sq  <= n_best_sq;
        r_best_den <= n_best_den;
        r_best_lvl <= n_best_lvl;
        r_thr      <= n_thr;
        r_ma       <= n_ma;
        r_mb       <= n_mb;
        r_acc      <= n_acc;
    end

    always_comb begin
        n_state    = r_state;
        n_total    = r_total;
        n_sum      = r_sum;
        n_lvl      = r_lvl;
        n_wb       = r_wb;
        n_wf       = r_wf;
        n_sumb     = r_sumb;
        n_sumf     = r_sumf;
        n_stop     = r_stop;
        n_pa       = r_pa;
        n_sq       = r_sq;
        n_den      = r_den;
        n_l        = r_l;
        n_have     = r_have;
        n_best_sq  = r_best_sq;
        n_best_den = r_best_den;
        n_best_lvl = r_best_lvl;
        n_thr      = r_thr;
        n_ma       = r_ma << 1;
        n_mb       = r_mb >> 1;
        n_acc      = r_mb[0] ? r_acc + r_ma : r_acc;
        mem_we     = 1'b0;
        mem_wa     = r_p1_addr;
        mem_wd     = new_cnt;
        mem_re     = 1'b0;
        mem_ra     = i_pixel;

        if (r_p1_valid) begin
            mem_we = 1'b1;
            if (cur_cnt != cap) begin
                n_sum = r_sum + SW'(r_p1_addr);
            end
            if (r_total != cap) begin
                n_total = r_total + 1'b1;
            end
        end

        unique case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                mem_wa = r_lvl;
                mem_wd = '0;
                n_lvl  = r_lvl + 1'b1;
                if (r_lvl == 8'hFF) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (i_valid) begin
                    mem_re = 1'b1;
                    if (i_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_lvl   = '0;
                n_wb    = '0;
                n_sumb  = '0;
                n_stop  = 1'b0;
                n_have  = 1'b0;
                n_best_sq  = '0;
                n_best_den = (2*CB)'(1);
                n_best_lvl = '0;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                mem_re  = 1'b1;
                mem_ra  = r_lvl;
                n_state = S_SCAN_WAIT;
            end
            S_SCAN_WAIT: begin
                mem_we = 1'b1;
                mem_wa = r_lvl;
                mem_wd = '0;
                n_lvl  = r_lvl + 1'b1;
                n_state = (r_lvl == 8'hFF) ? S_OUT : S_SCAN_RD;
                n_thr   = r_best_lvl;
                if (!r_stop) begin
                    if (wb_next == '0) begin
                        n_wb = '0;
                    end else if (wb_next >= {1'b0, r_total}) begin
                        n_stop = 1'b1;
                    end else begin
                        n_wb    = CB'(wb_next);
                        n_wf    = CB'({1'b0, r_total} - wb_next);
                        n_sumb  = sumb_next;
                        n_sumf  = r_sum - sumb_next;
                        n_lvl   = r_lvl;
                        n_state = S_MUL_PA;
                        n_ma    = LW'(sumb_next);
                        n_mb    = PW'(CB'({1'b0, r_total} - wb_next));
                        n_acc   = '0;
                    end
                end
            end
            S_MUL_PA: begin
                if (mul_done) begin
                    n_pa    = r_acc[PW-1:0];
                    n_ma    = LW'(r_sumf);
                    n_mb    = PW'(r_wb);
                    n_acc   = '0;
                    n_state = S_MUL_PB;
                end
            end
            S_MUL_PB: begin
                if (mul_done) begin
                    n_ma  = LW'(num_val);
                    n_mb  = num_val;
                    n_acc = '0;
                    if (num_val == '0) begin
                        n_lvl   = r_lvl + 1'b1;
                        n_thr   = r_best_lvl;
                        n_state = (r_lvl == 8'hFF) ? S_OUT : S_SCAN_RD;
                    end else begin
                        n_state = S_MUL_SQ;
                    end
                end
            end
            S_MUL_SQ: begin
                if (mul_done) begin
                    n_sq    = r_acc[2*PW-1:0];
                    n_ma    = LW'(r_wb);
                    n_mb    = PW'(r_wf);
                    n_acc   = '0;
                    n_state = S_MUL_DEN;
                end
            end
            S_MUL_DEN: begin
                if (mul_done) begin
                    n_den   = r_acc[2*CB-1:0];
                    n_ma    = LW'(r_sq);
                    n_mb    = PW'(r_best_den);
                    n_acc   = '0;
                    n_state = S_MUL_L;
                end
            end
            S_MUL_L: begin
                if (mul_done) begin
                    n_l     = r_acc;
                    n_ma    = LW'(r_best_sq);
                    n_mb    = PW'(r_den);
                    n_acc   = '0;
                    n_state = S_MUL_R;
                end
            end
            S_MUL_R: begin
                if (mul_done) begin
                    if (!r_have || r_l > r_acc) begin
                        n_have     = 1'b1;
                        n_best_sq  = r_sq;
                        n_best_den = r_den;
                        n_best_lvl = r_lvl;
                    end
                    n_thr   = (!r_have || r_l > r_acc) ? r_lvl : r_best_lvl;
                    n_lvl   = r_lvl + 1'b1;
                    n_state = (r_lvl == 8'hFF) ? S_OUT : S_SCAN_RD;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_total = '0;
                    n_sum   = '0;
                    n_state = S_ACC;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input and output both open");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last) |=> !o_ready)
        else $error("request taken after last pixel");

    a_p1_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid |-> (r_state == S_ACC || r_state == S_DRAIN))
        else $error("histogram update outside accumulation");

    a_fw_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fw_valid |-> $past(r_p1_valid))
        else $error("forward entry without prior update");
`endif
endmodule
`default_nettype wire

@@ bench/otsu_threshold_search_tb.sv @@
// Self-checking Otsu threshold search bench: fixed, random images, predicted thresholds.
`default_nettype none
module otsu_threshold_search_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import otsu_pkg::*;

    localparam int COUNT_BITS = 20;
    localparam int unsigned COUNT_CAP = (1 << COUNT_BITS) - 1;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } t_pixel_req;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_pixel = '0;
    logic       i_last = 1'b0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_threshold;

    t_pixel_req  pending_pixels[$];
    logic [7:0]  expected_thresholds[$];
    int unsigned hist_bins[LEVELS];
    int unsigned hist_total;
    int          planned;
    int          accepted;
    int          failures;

    otsu_threshold_search #(.COUNT_BITS(COUNT_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_pixel(i_pixel), .i_last(i_last),
        .o_valid(o_valid), .i_ready(i_ready), .o_threshold(o_threshold)
    );

    always #4 i_clk = ~i_clk;

    task automatic report(input string what);
        $display("tb: mismatch at %0t: %s", $realtime, what);
        failures++;
    endtask

    function automatic logic [7:0] otsu_level();
        logic [255:0] grand_sum, sum_b, sum_f, w_b, w_f, pa, pb, num, sq, den;
        logic [255:0] best_sq, best_den;
        logic         have_best;
        logic [7:0]   best_level;
        grand_sum = '0;
        sum_b = '0;
        w_b = '0;
        best_sq = '0;
        best_den = 256'd1;
        have_best = 1'b0;
        best_level = '0;
        for (int i = 0; i < LEVELS; i++)
            grand_sum += 256'(i) * 256'(hist_bins[i]);
        for (int i = 0; i < LEVELS; i++) begin
            w_b += 256'(hist_bins[i]);
            if (w_b == 0) continue;
            if (w_b >= 256'(hist_total)) break;
            w_f = 256'(hist_total) - w_b;
            sum_b += 256'(i) * 256'(hist_bins[i]);
            sum_f = grand_sum - sum_b;
            pa = sum_b * w_f;
            pb = sum_f * w_b;
            num = (pa >= pb) ? pa - pb : pb - pa;
            if (num == 0) continue;
            sq = num * num;
            den = w_b * w_f;
            if (!have_best || sq * best_den > best_sq * den) begin
                have_best = 1'b1;
                best_sq = sq;
                best_den = den;
                best_level = 8'(i);
            end
        end
        return best_level;
    endfunction

    task automatic count_pixel(input logic [7:0] pixel, input logic last);
        if (hist_bins[pixel] < COUNT_CAP) hist_bins[pixel]++;
        if (hist_total < COUNT_CAP) hist_total++;
        if (last) begin
            expected_thresholds.push_back(otsu_level());
            foreach (hist_bins[i]) hist_bins[i] = 0;
            hist_total = 0;
        end
    endtask

    function automatic int idle_percent(input bit sender);
        int phase;
        phase = (planned == 0) ? 2 : accepted * 3 / planned;
        if (phase == 0) return sender ? 20 : 66;
        if (phase == 1) return sender ? 66 : 20;
        return 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                count_pixel(i_pixel, i_last);
                accepted++;
            end
            if (!i_valid || o_ready) begin
                if (pending_pixels.size() > 0 && $urandom_range(99) >= idle_percent(1'b1)) begin
                    i_valid <= 1'b1;
                    i_pixel <= pending_pixels[0].pixel;
                    i_last  <= pending_pixels[0].last;
                    void'(pending_pixels.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_thresholds.size() == 0)
                    report($sformatf("unexpected threshold %0d", o_threshold));
                else begin
                    if (o_threshold !== expected_thresholds[0])
                        report($sformatf("threshold %0d, predicted %0d",
                                         o_threshold, expected_thresholds[0]));
                    void'(expected_thresholds.pop_front());
                end
            end
            i_ready <= ($urandom_range(99) >= idle_percent(1'b0));
        end
    end

    task automatic add_image(input logic [7:0] pixels[$]);
        foreach (pixels[i])
            pending_pixels.push_back('{pixel: pixels[i], last: (i == pixels.size() - 1)});
    endtask

    task automatic add_random_image();
        logic [7:0] pixels[$];
        int         len, style;
        logic [7:0] lo_c, hi_c;
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 16);
        style = $urandom_range(3);
        lo_c = 8'($urandom);
        hi_c = 8'($urandom);
        for (int i = 0; i < len; i++) begin
            case (style)
                0: pixels.push_back(8'($urandom));
                1: pixels.push_back($urandom_range(1) ? lo_c + 8'($urandom_range(3))
                                                      : hi_c - 8'($urandom_range(3)));
                2: pixels.push_back($urandom_range(1) ? lo_c : hi_c);
                default: pixels.push_back(8'($urandom_range(3)) * 8'd85);
            endcase
        end
        add_image(pixels);
    endtask

    initial begin
        failures = 0;
        accepted = 0;
        planned = 0;
        hist_total = 0;
        foreach (hist_bins[i]) hist_bins[i] = 0;
        add_image('{8'd0});
        add_image('{8'd255});
        add_image('{8'd7, 8'd7, 8'd7});
        add_image('{8'd0, 8'd255});
        add_image('{8'd255, 8'd0, 8'd255, 8'd0});
        add_image('{8'd10, 8'd20, 8'd30, 8'd40});
        add_image('{8'd0, 8'd128, 8'd255});
        add_image('{8'd170, 8'd85, 8'd1, 8'd2, 8'd254});
        while (pending_pixels.size() < 400) add_random_image();
        planned = pending_pixels.size();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_pixels.size() == 0);
        @(posedge i_clk);
        while (i_valid || expected_thresholds.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (failures == 0 && expected_thresholds.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #200ms;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/otsu_pkg.sv
rtl/core/otsu_threshold_search.sv
bench/otsu_threshold_search_tb.sv
